### rtl/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg
// Shared types, constants and arithmetic helpers of the symmetric COO
// sparse matrix-vector multiply block.
// ----------------------------------------------------------------------------
package smv_pkg;

  // Vector geometry.
  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned IDX_W   = $clog2(MAX_DIM);
  localparam int unsigned LEN_W   = IDX_W + 1;

  // Data widths: Q16.16 inputs, Q32.16 accumulators, full Q32.32 products.
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned FRAC_W = 16;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [LEN_W-1:0] VLEN_RESET = LEN_W'(MAX_DIM);

  // Command codes of an input item.
  typedef enum logic [2:0] {
    CMD_LOAD_X  = 3'd0,
    CMD_PRELOAD = 3'd1,
    CMD_NONZERO = 3'd2,
    CMD_READ    = 3'd3,
    CMD_DONE    = 3'd4
  } cmd_e;

  // Kind codes of a result item.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  // Sequencer states of the core.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_NZ1,
    S_NZ2,
    S_NZ3,
    S_EMIT
  } state_e;

  // One result item as held in the core.
  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  index;
    logic [ACC_W-1:0]  read_value;
  } res_t;

  // Add the floor-scaled product to an accumulator, saturating to 48 bits.
  function automatic logic [ACC_W-1:0] sat_accum(input logic [ACC_W-1:0]  acc,
                                                 input logic [PROD_W-1:0] prod);
    logic [ACC_W-1:0] scaled;
    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] res;
    // Dropping the low fraction bits of a two's complement value floors it.
    scaled = prod[FRAC_W +: ACC_W];
    sum    = {acc[ACC_W-1], acc} + {scaled[ACC_W-1], scaled};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      res = sum[ACC_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/smv_cmd_if.sv
// ----------------------------------------------------------------------------
// smv_cmd_if
// Command channel: valid/ready handshake with one command item as payload.
// ----------------------------------------------------------------------------
interface smv_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      cmd;
  logic [smv_pkg::IDX_W-1:0]       row_index;
  logic [smv_pkg::IDX_W-1:0]       col_index;
  logic signed [smv_pkg::VAL_W-1:0] value;

  modport source (output valid, output cmd, output row_index, output col_index,
                  output value, input ready);
  modport sink   (input valid, input cmd, input row_index, input col_index,
                  input value, output ready);
endinterface

### rtl/smv_rsp_if.sv
// ----------------------------------------------------------------------------
// smv_rsp_if
// Response channel: valid/ready handshake with one result item as payload.
// ----------------------------------------------------------------------------
interface smv_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       kind;
  logic [smv_pkg::IDX_W-1:0]        index;
  logic signed [smv_pkg::ACC_W-1:0] read_value;

  modport source (output valid, output kind, output index, output read_value,
                  input ready);
  modport sink   (input valid, input kind, input index, input read_value,
                  output ready);
endinterface

### rtl/smv_ram.sv
// ----------------------------------------------------------------------------
// smv_ram
// Generic simple dual-port RAM: one write port, one read port and
// registered read data.
// ----------------------------------------------------------------------------
module smv_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/smv_regs.sv
// ----------------------------------------------------------------------------
// smv_regs
// APB-style configuration register file holding the vector length.
// ----------------------------------------------------------------------------
module smv_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [smv_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [smv_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [smv_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [smv_pkg::LEN_W-1:0]          vector_length_o
);

  logic [smv_pkg::LEN_W-1:0] vlen_q;
  logic [smv_pkg::LEN_W-1:0] vlen_d;
  logic                      wr_en;

  // The only register sits at byte address 0.
  assign wr_en  = psel && penable && pwrite && (paddr == '0);
  assign vlen_d = wr_en ? pwdata[smv_pkg::LEN_W-1:0] : vlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= smv_pkg::VLEN_RESET;
    end else begin
      vlen_q <= vlen_d;
    end
  end

  // Reads return the register, zero extended.
  assign prdata          = smv_pkg::APB_DATA_W'(vlen_q);
  assign pready          = 1'b1;
  assign vector_length_o = vlen_q;

endmodule

### rtl/smv_core.sv
// ----------------------------------------------------------------------------
// smv_core
// Command sequencer with the x and accumulator memories, the product
// register and the saturating read-modify-write path, plus the output
// register of the response channel.
// ----------------------------------------------------------------------------
module smv_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [smv_pkg::LEN_W-1:0]  vector_length_i,
  smv_cmd_if.sink                    cmd_i,
  smv_rsp_if.source                  rsp_o
);

  smv_pkg::state_e state_q, state_d;

  // Latched item and datapath registers.
  logic [smv_pkg::IDX_W-1:0]  row_q, col_q;
  logic [smv_pkg::VAL_W-1:0]  val_q;
  logic [smv_pkg::PROD_W-1:0] prod_q;
  logic [smv_pkg::ACC_W-1:0]  acc_q;
  smv_pkg::res_t              res_q, out_q;
  logic                       out_valid_q;

  // Control from the sequencer.
  logic latch_item, cap_prod, res_valid, load_out, hold_res, out_free;
  smv_pkg::res_t res;

  // Memory ports.
  logic                       x_we, x_re, acc_we, acc_re;
  logic [smv_pkg::IDX_W-1:0]  x_waddr, x_raddr, acc_waddr, acc_raddr;
  logic [smv_pkg::VAL_W-1:0]  x_wdata, x_rdata;
  logic [smv_pkg::ACC_W-1:0]  acc_wdata, acc_rdata;

  // Range check against the effective vector length.
  logic [smv_pkg::LEN_W-1:0] len_eff;
  logic                      row_ok, col_ok;

  logic signed [smv_pkg::PROD_W-1:0] prod_d;

  assign len_eff = (vector_length_i > smv_pkg::LEN_W'(smv_pkg::MAX_DIM))
                   ? smv_pkg::LEN_W'(smv_pkg::MAX_DIM) : vector_length_i;
  assign row_ok  = {1'b0, cmd_i.row_index} < len_eff;
  assign col_ok  = {1'b0, cmd_i.col_index} < len_eff;

  assign out_free = !out_valid_q || rsp_o.ready;

  // Product of the latched matrix value and the x element just read.
  assign prod_d = $signed(val_q) * $signed(x_rdata);

  smv_ram #(.DEPTH(smv_pkg::MAX_DIM), .WIDTH(smv_pkg::VAL_W)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (x_waddr),
    .wdata_i (x_wdata),
    .re_i    (x_re),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  smv_ram #(.DEPTH(smv_pkg::MAX_DIM), .WIDTH(smv_pkg::ACC_W)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smv_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, memory accesses and result generation.
  always_comb begin
    state_d    = state_q;
    cmd_i.ready = 1'b0;
    latch_item = 1'b0;
    cap_prod   = 1'b0;
    res_valid  = 1'b0;
    res        = '{kind: smv_pkg::KIND_DONE, index: '0, read_value: '0};
    x_we       = 1'b0;
    x_waddr    = cmd_i.row_index;
    x_wdata    = cmd_i.value;
    x_re       = 1'b0;
    x_raddr    = cmd_i.col_index;
    acc_we     = 1'b0;
    acc_waddr  = cmd_i.row_index;
    acc_wdata  = smv_pkg::ACC_W'(cmd_i.value);
    acc_re     = 1'b0;
    acc_raddr  = cmd_i.row_index;

    unique case (state_q)
      smv_pkg::S_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_i.valid) begin
          latch_item = 1'b1;
          case (cmd_i.cmd) inside
            smv_pkg::CMD_LOAD_X, smv_pkg::CMD_PRELOAD, smv_pkg::CMD_READ: begin
              if (!row_ok) begin
                res_valid = 1'b1;
                res = '{kind: smv_pkg::KIND_ERROR, index: cmd_i.row_index,
                        read_value: '0};
              end else if (cmd_i.cmd == smv_pkg::CMD_LOAD_X) begin
                x_we = 1'b1;
              end else if (cmd_i.cmd == smv_pkg::CMD_PRELOAD) begin
                acc_we = 1'b1;
              end else begin
                acc_re  = 1'b1;
                state_d = smv_pkg::S_RD;
              end
            end
            smv_pkg::CMD_NONZERO: begin
              if (!row_ok) begin
                res_valid = 1'b1;
                res = '{kind: smv_pkg::KIND_ERROR, index: cmd_i.row_index,
                        read_value: '0};
              end else if (!col_ok) begin
                res_valid = 1'b1;
                res = '{kind: smv_pkg::KIND_ERROR, index: cmd_i.col_index,
                        read_value: '0};
              end else begin
                // Fetch x[col] and accum[row] for the first update.
                x_re    = 1'b1;
                acc_re  = 1'b1;
                state_d = smv_pkg::S_NZ1;
              end
            end
            smv_pkg::CMD_DONE: begin
              res_valid = 1'b1;
            end
            default: begin
            end
          endcase
          if (res_valid && !out_free) begin
            state_d = smv_pkg::S_EMIT;
          end
        end
      end
      smv_pkg::S_RD: begin
        res_valid = 1'b1;
        res = '{kind: smv_pkg::KIND_DATA, index: row_q, read_value: acc_rdata};
        state_d = out_free ? smv_pkg::S_IDLE : smv_pkg::S_EMIT;
      end
      smv_pkg::S_NZ1: begin
        // Capture the first product; fetch x[row] and accum[col] for the mirror.
        cap_prod  = 1'b1;
        x_raddr   = row_q;
        acc_raddr = col_q;
        x_re      = (row_q != col_q);
        acc_re    = (row_q != col_q);
        state_d   = smv_pkg::S_NZ2;
      end
      smv_pkg::S_NZ2: begin
        acc_we    = 1'b1;
        acc_waddr = row_q;
        acc_wdata = smv_pkg::sat_accum(acc_q, prod_q);
        if (row_q != col_q) begin
          cap_prod = 1'b1;
          state_d  = smv_pkg::S_NZ3;
        end else begin
          state_d  = smv_pkg::S_IDLE;
        end
      end
      smv_pkg::S_NZ3: begin
        acc_we    = 1'b1;
        acc_waddr = col_q;
        acc_wdata = smv_pkg::sat_accum(acc_q, prod_q);
        state_d   = smv_pkg::S_IDLE;
      end
      smv_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = smv_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = smv_pkg::S_IDLE;
      end
    endcase
  end

  // A fresh result goes straight to the output register when it is free;
  // otherwise it waits in the hold register.
  assign load_out = (res_valid || (state_q == smv_pkg::S_EMIT)) && out_free;
  assign hold_res = res_valid && !out_free;

  // Item, product and hold registers.
  always_ff @(posedge clk_i) begin
    if (latch_item) begin
      row_q <= cmd_i.row_index;
      col_q <= cmd_i.col_index;
      val_q <= cmd_i.value;
    end
    if (cap_prod) begin
      prod_q <= prod_d;
      acc_q  <= acc_rdata;
    end
    if (hold_res) begin
      res_q <= res;
    end
    if (load_out) begin
      out_q <= (state_q == smv_pkg::S_EMIT) ? res_q : res;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.kind       = out_q.kind;
  assign rsp_o.index      = out_q.index;
  assign rsp_o.read_value = out_q.read_value;

`ifndef SYNTHESIS
  // The mirrored update only runs for an entry off the diagonal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smv_pkg::S_NZ3 |-> row_q != col_q)
    else $error("mirror update on a diagonal entry");

  // The output register is loaded only when it is empty or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || rsp_o.ready))
    else $error("output register overwritten");

  // The first nonzero fetch always leads to the first update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smv_pkg::S_NZ1 |=> state_q == smv_pkg::S_NZ2)
    else $error("nonzero sequence broken");

  // A held result stays held while the output is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smv_pkg::S_EMIT && !out_free) |=> state_q == smv_pkg::S_EMIT)
    else $error("held result dropped");
`endif

endmodule

### rtl/sym_coo_sparse_matvec_top.sv
// ----------------------------------------------------------------------------
// sym_coo_sparse_matvec_top
// Symmetric sparse matrix-vector multiply over coordinate triples of one
// triangle, with Q16.16 inputs and saturating Q32.16 accumulators.
//
//   Channel   Dir  Handshake            Contents
//   cmd_i     in   valid/ready          cmd, row_index, col_index, value
//   rsp_o     out  valid/ready          kind, index, read_value
//   APB       in   psel/penable/pready  vector_length at address 0
//
// Load x, preload, done and every range error finish in S_IDLE, so they can
// follow each other back to back while the output register is free. A read
// passes through S_RD, a nonzero through S_NZ1 and S_NZ2, and an off-diagonal
// one also through S_NZ3. Reset clears control only; memory contents are
// undefined until written, so no clearing pass runs. A finished result waits
// in the output register while new items without a result are still taken;
// a second result waits in the hold register and stalls the command side.
// ----------------------------------------------------------------------------
module sym_coo_sparse_matvec_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [smv_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [smv_pkg::APB_DATA_W-1:0] pwdata,
  output logic [smv_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  smv_cmd_if.sink                        cmd_i,
  smv_rsp_if.source                      rsp_o
);

  logic [smv_pkg::LEN_W-1:0] vector_length;

  // Configuration registers.
  smv_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .vector_length_o (vector_length)
  );

  // Sequencer, memories and arithmetic.
  smv_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vector_length_i (vector_length),
    .cmd_i           (cmd_i),
    .rsp_o           (rsp_o)
  );

endmodule
